FILE: hw/rtl/demand_paging_table_allocator_defines.svh
// assertion macros shared by the page table allocator modules
`ifndef DEMAND_PAGING_TABLE_ALLOCATOR_DEFINES_SVH
`define DEMAND_PAGING_TABLE_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DPTA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define DPTA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/dpta_pkg.sv
// types and constants of the page table allocator
`timescale 1ns / 1ps

package dpta_pkg;

   localparam int PID_W    = 4;
   localparam int VPAGE_W  = 6;
   localparam int FRAME_W  = 8;
   localparam int REFS_W   = 8;
   localparam int CNT_W    = 9;
   localparam int PCOUNT_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CNT_W-1:0]    CNT_MAX = 9'd511;
   localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 5'd1;

   // register index, taken from paddr above the byte offset
   localparam logic [CSR_ADDR_W-3:0] REG_PROCESS_COUNT = 1'b0;

   typedef struct packed {
      logic [PID_W-1:0]   process_index;
      logic [VPAGE_W-1:0] virtual_page;
   } req_item_type;

   typedef struct packed {
      logic               hit;
      logic               fault;
      logic [FRAME_W-1:0] physical_frame;
      logic [REFS_W-1:0]  page_ref_count;
      logic               out_of_memory;
      logic [CNT_W-1:0]   process_faults;
      logic [CNT_W-1:0]   process_references;
      logic [CNT_W-1:0]   frames_used;
   } rsp_item_type;

   typedef struct packed {
      logic               valid;
      logic [REFS_W-1:0]  refs;
      logic [FRAME_W-1:0] frame;
   } entry_type;

   typedef struct packed {
      logic clear_wr;
      logic lookup_rd;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_free;
   } status_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      return (c == CNT_MAX) ? c : c + 1'b1;
   endfunction

endpackage

FILE: hw/rtl/demand_paging_table_allocator.sv
// top level of the demand paging table allocator
//
//   channel  direction  handshake                    payload
//   req      in         req_valid / req_ready        req_item (process_index, virtual_page)
//   rsp      out        rsp_valid / rsp_ready        rsp_item (hit ... frames_used)
//   csr      in/out     csr_psel/penable/pwrite      csr_paddr, csr_pwdata, csr_prdata
//
// the accept cycle reads the page table entry memory; in lookup, once the result register
// is free, the entry and counters are read-modify-written and the result register loaded.
// the result register frees the input side; a lookup waits only while it is still full.
// after reset a clearing pass over all MAX_PROCESSES * PAGES_PER_PROCESS entries (1024 by
// default) empties the entry memory with req_ready low; csr writes are taken throughout.
`timescale 1ns / 1ps

module demand_paging_table_allocator #(
   parameter int MAX_PROCESSES     = 16,
   parameter int PAGES_PER_PROCESS = 64,
   parameter int PHYS_FRAMES       = 256,
   parameter int TABLE_FRAMES      = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  dpta_pkg::req_item_type          req_item,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output dpta_pkg::rsp_item_type          rsp_item,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [dpta_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [dpta_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [dpta_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   dpta_pkg::cmd_type    cmd;
   dpta_pkg::status_type status;

   assign csr_pready = 1'b1;

   dpta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   dpta_datapath #(
      .MAX_PROCESSES     (MAX_PROCESSES),
      .PAGES_PER_PROCESS (PAGES_PER_PROCESS),
      .PHYS_FRAMES       (PHYS_FRAMES),
      .TABLE_FRAMES      (TABLE_FRAMES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_item    (req_item),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata)
   );

endmodule

FILE: hw/rtl/dpta_ctrl.sv
// controller state machine: clearing pass, accept, lookup and commit
`timescale 1ns / 1ps
`include "demand_paging_table_allocator_defines.svh"

module dpta_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output dpta_pkg::cmd_type    cmd,
   input  dpta_pkg::status_type status
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         req_ready_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_ready     = req_ready_ff;
   assign cmd.clear_wr  = (state_ff == ST_CLEAR);
   assign cmd.lookup_rd = req_valid & req_ready_ff;
   // commit only when the result register can take the item
   assign cmd.commit    = (state_ff == ST_LOOKUP) & status.out_free;

   `DPTA_ASSERT_NEXT(a_accept_then_lookup, cmd.lookup_rd, (state_ff == ST_LOOKUP) && !req_ready_ff, "accepted item did not move to lookup")

endmodule

FILE: hw/rtl/dpta_datapath.sv
// datapath: entry memory, per-process counters, frame pointer, result register, csr
`timescale 1ns / 1ps
`include "demand_paging_table_allocator_defines.svh"

module dpta_datapath #(
   parameter int MAX_PROCESSES     = 16,
   parameter int PAGES_PER_PROCESS = 64,
   parameter int PHYS_FRAMES       = 256,
   parameter int TABLE_FRAMES      = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  dpta_pkg::cmd_type                      cmd,
   output dpta_pkg::status_type                   status,
   input  dpta_pkg::req_item_type                 req_item,
   input  logic                                   rsp_ready,
   output logic                                   rsp_valid,
   output dpta_pkg::rsp_item_type                 rsp_item,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [dpta_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [dpta_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [dpta_pkg::CSR_DATA_W-1:0]        csr_prdata
);

   localparam int DEPTH  = MAX_PROCESSES * PAGES_PER_PROCESS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PIDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int BASE_W = dpta_pkg::PCOUNT_W + 5;

   // entry memory
   dpta_pkg::entry_type mem [DEPTH];
   dpta_pkg::entry_type rd_data_ff;
   logic [ADDR_W-1:0]   clear_addr_ff;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   dpta_pkg::entry_type mem_wdata;
   logic [ADDR_W-1:0]   rd_addr;
   logic                rd_ok;

   // state
   dpta_pkg::req_item_type        req_ff;
   logic [dpta_pkg::CNT_W-1:0]    faults_ff [MAX_PROCESSES];
   logic [dpta_pkg::CNT_W-1:0]    refs_ff   [MAX_PROCESSES];
   logic [dpta_pkg::CNT_W-1:0]    next_free_ff;
   logic                          halted_ff;
   logic [dpta_pkg::PCOUNT_W-1:0] process_count_ff;
   logic                          rsp_valid_ff;
   dpta_pkg::rsp_item_type        rsp_ff;

   // lookup logic
   logic                       pi_ok, vp_ok, live, act;
   logic                       is_hit, is_fault, is_oom, halted_in;
   logic [PIDX_W-1:0]          pidx;
   logic [ADDR_W-1:0]          wr_addr;
   logic [dpta_pkg::CNT_W-1:0] faults_cur, refs_cur, faults_new, refs_new;
   logic [dpta_pkg::REFS_W-1:0]  entry_refs_new;
   logic [dpta_pkg::FRAME_W-1:0] entry_frame_new;
   dpta_pkg::rsp_item_type     result;

   // csr
   logic                    csr_wr;
   logic                    csr_hit;
   logic [BASE_W-1:0]       base_full;
   logic [dpta_pkg::CNT_W-1:0] base_sat;

   // read address of an arriving item; out-of-range items read entry zero
   assign rd_ok   = (32'(req_item.process_index) < MAX_PROCESSES) &&
                    (32'(req_item.virtual_page) < PAGES_PER_PROCESS);
   assign rd_addr = rd_ok ? ADDR_W'(32'(req_item.process_index) * PAGES_PER_PROCESS +
                                    32'(req_item.virtual_page))
                          : '0;

   // held item
   assign pi_ok   = (32'(req_ff.process_index) < MAX_PROCESSES);
   assign vp_ok   = (32'(req_ff.virtual_page) < PAGES_PER_PROCESS);
   assign live    = pi_ok && vp_ok &&
                    ({1'b0, req_ff.process_index} < process_count_ff);
   assign act     = live & ~halted_ff;
   assign pidx    = PIDX_W'(req_ff.process_index);
   assign wr_addr = ADDR_W'(32'(req_ff.process_index) * PAGES_PER_PROCESS +
                            32'(req_ff.virtual_page));

   assign is_hit    = act & rd_data_ff.valid;
   assign is_oom    = act & ~rd_data_ff.valid &
                      (next_free_ff >= dpta_pkg::CNT_W'(PHYS_FRAMES));
   assign is_fault  = act & ~rd_data_ff.valid & ~is_oom;
   assign halted_in = halted_ff | is_oom;

   assign faults_cur = pi_ok ? faults_ff[pidx] : '0;
   assign refs_cur   = pi_ok ? refs_ff[pidx] : '0;
   assign faults_new = is_fault ? dpta_pkg::sat_inc(faults_cur) : faults_cur;
   assign refs_new   = (is_hit | is_fault) ? dpta_pkg::sat_inc(refs_cur) : refs_cur;

   // an invalid entry always holds zero refs, so a fault also lands on one
   assign entry_refs_new  = rd_data_ff.refs + 1'b1;
   assign entry_frame_new = is_fault ? next_free_ff[dpta_pkg::FRAME_W-1:0]
                                     : rd_data_ff.frame;

   always_comb begin
      result                    = '0;
      result.hit                = is_hit;
      result.fault              = is_fault;
      if (is_hit | is_fault) begin
         result.physical_frame  = entry_frame_new;
         result.page_ref_count  = entry_refs_new;
      end
      result.out_of_memory      = halted_in;
      result.process_faults     = faults_new;
      result.process_references = refs_new;
      result.frames_used        = is_fault ? next_free_ff + 1'b1 : next_free_ff;
   end

   // memory write port: clearing pass or commit of a hit or fault
   always_comb begin
      if (cmd.clear_wr) begin
         mem_we    = 1'b1;
         mem_waddr = clear_addr_ff;
         mem_wdata = '0;
      end else begin
         mem_we          = cmd.commit & (is_hit | is_fault);
         mem_waddr       = wr_addr;
         mem_wdata.valid = 1'b1;
         mem_wdata.refs  = entry_refs_new;
         mem_wdata.frame = entry_frame_new;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (cmd.lookup_rd) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
      end else if (cmd.clear_wr) begin
         clear_addr_ff <= clear_addr_ff + 1'b1;
      end
   end

   assign status.clear_last = (32'(clear_addr_ff) == DEPTH - 1);
   assign status.out_free   = ~rsp_valid_ff | rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.lookup_rd) req_ff <= req_item;
   end

   // csr decode and table base
   assign csr_wr    = csr_psel & csr_penable & csr_pwrite;
   assign csr_hit   = (csr_paddr[dpta_pkg::CSR_ADDR_W-1:2] == dpta_pkg::REG_PROCESS_COUNT);
   assign base_full = BASE_W'(csr_pwdata[dpta_pkg::PCOUNT_W-1:0]) * BASE_W'(TABLE_FRAMES);
   assign base_sat  = (base_full > BASE_W'(dpta_pkg::CNT_MAX)) ? dpta_pkg::CNT_MAX
                                                               : dpta_pkg::CNT_W'(base_full);
   assign csr_prdata = csr_hit ? dpta_pkg::CSR_DATA_W'(process_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         process_count_ff <= dpta_pkg::PCOUNT_RESET;
         next_free_ff     <= dpta_pkg::CNT_W'(TABLE_FRAMES);
         halted_ff        <= 1'b0;
         for (int i = 0; i < MAX_PROCESSES; i++) begin
            faults_ff[i] <= '0;
            refs_ff[i]   <= '0;
         end
      end else begin
         if (csr_wr && csr_hit) begin
            process_count_ff <= csr_pwdata[dpta_pkg::PCOUNT_W-1:0];
            next_free_ff     <= base_sat;
         end else if (cmd.commit && is_fault) begin
            next_free_ff     <= next_free_ff + 1'b1;
         end
         if (cmd.commit) begin
            halted_ff <= halted_in;
            if (act) begin
               faults_ff[pidx] <= faults_new;
               refs_ff[pidx]   <= refs_new;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) rsp_ff <= result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `DPTA_ASSERT_NEXT(a_fault_bumps_pointer, cmd.commit && is_fault, next_free_ff == $past(next_free_ff) + 1'b1, "fault did not advance the frame pointer")
   `DPTA_ASSERT_NEXT(a_halt_sticky, halted_ff, halted_ff, "out-of-memory flag cleared")
   `DPTA_ASSERT_NOW(a_no_commit_in_clear, cmd.clear_wr, !cmd.commit && !cmd.lookup_rd, "item work during clearing pass")

endmodule

FILE: tb/tb.sv
// testbench for the demand paging table allocator: random references checked against a predictor
`timescale 1ns / 1ps

module tb;

   localparam int QUIET_LIMIT = 4000;
   localparam int TABLE_SLOTS = 8;
   localparam logic [dpta_pkg::CSR_ADDR_W-1:0] PCOUNT_ADDR =
      {dpta_pkg::REG_PROCESS_COUNT, 2'b00};

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   dpta_pkg::req_item_type          req_item = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   dpta_pkg::rsp_item_type          rsp_item;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [dpta_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [dpta_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [dpta_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   demand_paging_table_allocator uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted page tables, counters and frame pool
   logic                          pt_valid [16][64];
   logic [dpta_pkg::FRAME_W-1:0]  pt_frame [16][64];
   logic [dpta_pkg::REFS_W-1:0]   pt_refs  [16][64];
   logic [dpta_pkg::CNT_W-1:0]    faults_seen [16];
   logic [dpta_pkg::CNT_W-1:0]    refs_seen [16];
   logic [dpta_pkg::CNT_W-1:0]    frame_ptr;
   logic                          oom;
   logic [dpta_pkg::PCOUNT_W-1:0] live_procs;

   dpta_pkg::req_item_type pending_refs[$];
   dpta_pkg::rsp_item_type expected_lookups[$];

   int send_wait = 0;
   int recv_wait = 0;
   bit send_calm = 1'b0;
   bit recv_calm = 1'b0;
   int mismatches = 0;
   int refs_checked = 0;
   int hits_seen = 0;
   int faults_taken = 0;
   int wraps_seen = 0;
   int saturated_seen = 0;
   int oom_seen = 0;

   function automatic logic [dpta_pkg::CNT_W-1:0] sat_step(
      input logic [dpta_pkg::CNT_W-1:0] c);
      return (c == '1) ? c : c + 1'b1;
   endfunction

   function automatic dpta_pkg::rsp_item_type translate_ref(input dpta_pkg::req_item_type r);
      dpta_pkg::rsp_item_type o;
      int p;
      int v;
      o = '0;
      p = r.process_index;
      v = r.virtual_page;
      if (p < live_procs && !oom) begin
         if (pt_valid[p][v]) begin
            pt_refs[p][v] = pt_refs[p][v] + 1'b1;
            refs_seen[p] = sat_step(refs_seen[p]);
            o.hit = 1'b1;
            o.physical_frame = pt_frame[p][v];
            o.page_ref_count = pt_refs[p][v];
         end else if (frame_ptr >= 9'd256) begin
            oom = 1'b1;
         end else begin
            faults_seen[p] = sat_step(faults_seen[p]);
            refs_seen[p] = sat_step(refs_seen[p]);
            pt_frame[p][v] = frame_ptr[dpta_pkg::FRAME_W-1:0];
            pt_refs[p][v] = pt_refs[p][v] + 1'b1;
            pt_valid[p][v] = 1'b1;
            frame_ptr = frame_ptr + 1'b1;
            o.fault = 1'b1;
            o.physical_frame = pt_frame[p][v];
            o.page_ref_count = pt_refs[p][v];
         end
      end
      o.out_of_memory = oom;
      o.process_faults = faults_seen[p];
      o.process_references = refs_seen[p];
      o.frames_used = frame_ptr;
      return o;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // sender: one item in flight on the req channel, random gaps between items
   always @(posedge clock) begin : drive_req
      logic hold;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else begin
         hold = req_valid && !req_ready;
         if (req_valid && req_ready)
            expected_lookups.push_back(translate_ref(req_item));
         if (!hold) begin
            if (send_wait > 0) begin
               req_valid <= 1'b0;
               send_wait <= send_wait - 1;
            end else if (pending_refs.size() > 0) begin
               req_valid <= 1'b1;
               req_item <= pending_refs.pop_front();
               if ($urandom_range(0, 39) == 0)
                  send_calm = !send_calm;
               send_wait <= send_calm ? 0 : $urandom_range(0, 5);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each result against the oldest prediction
   always @(posedge clock) begin : check_rsp
      dpta_pkg::rsp_item_type want;
      int w;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait <= 0;
      end else begin
         w = recv_wait;
         if (rsp_valid && rsp_ready) begin
            if (expected_lookups.size() == 0) begin
               $error("result with no reference outstanding");
               mismatches++;
            end else begin
               want = expected_lookups.pop_front();
               refs_checked++;
               if (want.hit) hits_seen++;
               if (want.fault) faults_taken++;
               if (want.hit && want.page_ref_count == 0) wraps_seen++;
               if (want.process_references == dpta_pkg::CNT_MAX) saturated_seen++;
               if (want.out_of_memory) oom_seen++;
               check_field("hit", want.hit, rsp_item.hit);
               check_field("fault", want.fault, rsp_item.fault);
               check_field("physical_frame", want.physical_frame, rsp_item.physical_frame);
               check_field("page_ref_count", want.page_ref_count, rsp_item.page_ref_count);
               check_field("out_of_memory", want.out_of_memory, rsp_item.out_of_memory);
               check_field("process_faults", want.process_faults, rsp_item.process_faults);
               check_field("process_references", want.process_references,
                           rsp_item.process_references);
               check_field("frames_used", want.frames_used, rsp_item.frames_used);
            end
            if ($urandom_range(0, 39) == 0)
               recv_calm = !recv_calm;
            w = recv_calm ? 0 : $urandom_range(0, 5);
         end
         if (w > 0) begin
            rsp_ready <= 1'b0;
            recv_wait <= w - 1;
         end else begin
            rsp_ready <= 1'b1;
            recv_wait <= 0;
         end
      end
   end

   // ends the run when neither channel moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb: failure");
      $finish;
   end

   task automatic csr_write(input logic [dpta_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [dpta_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic csr_read(input logic [dpta_pkg::CSR_ADDR_W-1:0] addr,
                           output logic [dpta_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      data = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // rewriting the count also moves the frame pointer back to the end of the tables
   task automatic set_process_count(input int count);
      logic [dpta_pkg::CSR_DATA_W-1:0] readback;
      csr_write(PCOUNT_ADDR, dpta_pkg::CSR_DATA_W'(count));
      live_procs = dpta_pkg::PCOUNT_W'(count);
      frame_ptr = dpta_pkg::CNT_W'(32'(live_procs) * TABLE_SLOTS);
      csr_read(PCOUNT_ADDR, readback);
      check_field("process_count", count, readback);
      @(negedge clock);
   endtask

   task automatic add_ref(input int p, input int v);
      dpta_pkg::req_item_type r;
      r.process_index = dpta_pkg::PID_W'(p);
      r.virtual_page = dpta_pkg::VPAGE_W'(v);
      pending_refs.push_back(r);
   endtask

   // outside hot mode, live references stay within pages 0..page_hi so the pool only runs dry when wanted;
   // hot mode piles references onto pages 0 and 1
   task automatic queue_refs(input int count, input int pcount, input int page_hi, input bit hot);
      dpta_pkg::req_item_type r;
      int live_hi;
      int w;
      live_hi = (pcount > 16) ? 15 : pcount - 1;
      repeat (count) begin
         if (pcount > 0 && $urandom_range(0, 99) < 85)
            r.process_index = dpta_pkg::PID_W'($urandom_range(0, live_hi));
         else
            r.process_index = dpta_pkg::PID_W'($urandom_range(0, 15));
         w = $urandom_range(0, 99);
         if (r.process_index >= pcount)
            r.virtual_page = dpta_pkg::VPAGE_W'($urandom_range(0, 63));
         else if (hot && w < 50)
            r.virtual_page = '0;
         else if (hot && w < 80)
            r.virtual_page = dpta_pkg::VPAGE_W'(1);
         else if (hot)
            r.virtual_page = dpta_pkg::VPAGE_W'($urandom_range(0, 63));
         else
            r.virtual_page = dpta_pkg::VPAGE_W'($urandom_range(0, page_hi));
         pending_refs.push_back(r);
      end
   endtask

   task automatic drain();
      while (pending_refs.size() != 0 || req_valid || expected_lookups.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin : run
      for (int p = 0; p < 16; p++) begin
         faults_seen[p] = '0;
         refs_seen[p] = '0;
         for (int v = 0; v < 64; v++) begin
            pt_valid[p][v] = 1'b0;
            pt_frame[p][v] = '0;
            pt_refs[p][v] = '0;
         end
      end
      live_procs = dpta_pkg::PCOUNT_RESET;
      frame_ptr = dpta_pkg::CNT_W'(32'(live_procs) * TABLE_SLOTS);
      oom = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset count of one: first fault, hits, top page, processes outside the live set
      add_ref(0, 0);
      add_ref(0, 0);
      add_ref(0, 63);
      add_ref(0, 63);
      add_ref(1, 0);
      add_ref(15, 63);
      add_ref(15, 0);
      add_ref(0, 0);
      drain();

      set_process_count(16);
      add_ref(15, 63);
      add_ref(15, 63);
      add_ref(8, 42);
      add_ref(15, 0);
      add_ref(7, 5);
      queue_refs(250, 16, 5, 1'b0);
      drain();
      queue_refs(250, 16, 5, 1'b0);
      drain();

      // no live process: every reference ignored
      set_process_count(0);
      add_ref(0, 0);
      queue_refs(20, 0, 63, 1'b0);
      drain();

      // one process hammered: reference count wraps, process counter saturates
      set_process_count(1);
      queue_refs(700, 1, 63, 1'b1);
      drain();

      set_process_count(5);
      queue_refs(400, 5, 31, 1'b0);
      drain();

      // tables fill all but eight frames: the pool runs out and stays out
      set_process_count(31);
      add_ref(15, 63);
      queue_refs(150, 31, 63, 1'b0);
      drain();

      repeat (10) @(posedge clock);
      $display("tb: %0d references checked: %0d hits, %0d faults, %0d after the pool ran out",
               refs_checked, hits_seen, faults_taken, oom_seen);
      $display("tb: process counts 1, 16, 0, 5, 31; %0d refcount wraps, %0d saturated counters",
               wraps_seen, saturated_seen);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
